// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

   // field widths of the word formats
   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // action codes
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_ENQUEUED  = 2'd0,
      ST_DEQUEUED  = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL_DROP = 2'd3
   } status_type;

   // one stored entry
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type ent;
   } cmd_type;

endpackage

// ===== hw/rtl/stable_min_priority_queue_unit.sv =====
`timescale 1ns / 1ps

// Sorted priority queue of CAPACITY entries built as a row of cells, slot 0 at the
// head. Every cell compares its priority with the incoming one in parallel and either
// holds, shifts toward the tail or shifts toward the head, so one word is taken every
// clock: busy never rises and the result strobe rises in the cycle after acceptance.
// The rate is set by the cell update together with the fill counter.
// Results cannot be held off, so the receiver must take each word in its strobe cycle.
// Equal priorities leave in arrival order. A dequeue on an empty queue and an enqueue
// on a full queue change nothing and report their own status. No clearing pass is
// needed after reset; the fill count alone marks which cells hold data.
module stable_min_priority_queue_unit import spq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [VALUE_W-1:0]  req_value_in,
   input  logic [PRIO_W-1:0]   req_priority_in,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  rsp_result_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [VALUE_W-1:0] rsp_value_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic               accept;
   logic               full;
   logic               empty;
   cmd_type            cmd;
   entry_type          ents [CAPACITY];
   logic               gts  [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = count_ff == CW'(CAPACITY);
   assign empty  = count_ff == '0;

   // command decode and result word
   always_comb begin
      cmd.enq       = accept && (req_action == ACT_ENQUEUE) && !full;
      cmd.deq       = accept && (req_action == ACT_DEQUEUE) && !empty;
      cmd.ent.value = req_value_in;
      cmd.ent.prio  = req_priority_in;
      count_in      = count_ff;
      rsp_value_in  = '0;
      if (req_action == ACT_ENQUEUE) begin
         rsp_status_in = full ? ST_FULL_DROP : ST_ENQUEUED;
      end else begin
         rsp_status_in = empty ? ST_EMPTY : ST_DEQUEUED;
      end
      if (cmd.enq) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.deq) begin
         count_in     = count_ff - CW'(1);
         rsp_value_in = ents[0].value;
      end
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type lent;
      entry_type rent;
      logic      lgt;
      if (i == 0) begin : g_head
         assign lent = cmd.ent;
         assign lgt  = 1'b0;
      end else begin : g_mid
         assign lent = ents[i-1];
         assign lgt  = gts[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign rent = ents[i];
      end else begin : g_body
         assign rent = ents[i+1];
      end
      spq_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .left_ent  (lent),
         .left_gt   (lgt),
         .right_ent (rent),
         .ent       (ents[i]),
         .gt        (gts[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = OCC_W'(count_ff);

   // fill count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   // one strobe for each accepted word
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("missing result strobe");

   // enqueue into a non-full queue grows the count by one
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.enq |=> count_ff == $past(count_ff) + CW'(1))
      else $error("enqueue did not grow the count");

   // head pair stays in ascending priority order
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff > CW'(1) |-> $signed(ents[0].prio) <= $signed(ents[1].prio))
      else $error("head entries out of order");

   // a dequeue result reports the count after removal
   a_deq_status: assert property (@(posedge clock) disable iff (reset)
      cmd.deq |=> rsp_status == ST_DEQUEUED && count_ff == $past(count_ff) - CW'(1))
      else $error("dequeue bookkeeping wrong");

endmodule

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic          clock,
   input  cmd_type       cmd,
   input  logic [CW-1:0] count,
   input  entry_type     left_ent,
   input  logic          left_gt,
   input  entry_type     right_ent,
   output entry_type     ent,
   output logic          gt
);

   entry_type store_ff;
   entry_type store_in;
   logic      occ;
   logic      at_tail;

   // occupancy from the fill count and the insertion decision
   always_comb begin
      occ      = count > CW'(INDEX);
      at_tail  = count == CW'(INDEX);
      gt       = occ && ($signed(store_ff.prio) > $signed(cmd.ent.prio));
      store_in = store_ff;
      if (cmd.enq) begin
         if (gt || at_tail) begin
            store_in = left_gt ? left_ent : cmd.ent;
         end
      end else if (cmd.deq) begin
         store_in = right_ent;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   assign ent = store_ff;

endmodule
